@@ rtl/chpt_pkg.sv @@
// ----------------------------------------------------------------------------
// chpt_pkg
// shared types and constants for the coil pulse holdoff timer
// ----------------------------------------------------------------------------
package chpt_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int TIME_W      = 32;
    localparam int MS_W        = 16;
    localparam int READY_W     = 17;

    localparam logic [MS_W-1:0] PULSE_LENGTH_RST = 16'd50;
    localparam logic [MS_W-1:0] MAX_ON_RST       = 16'd100;
    localparam logic [MS_W-1:0] COOLDOWN_RST     = 16'd500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PULSE_LENGTH  = 3'd0,
        REG_MAX_ON        = 3'd1,
        REG_COOLDOWN      = 3'd2,
        REG_BUTTON_PRES   = 3'd3,
        REG_BUTTON_ACTIVE = 3'd4,
        REG_FIRE_POL      = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_FIRE   = 2'd1,
        CMD_RESET  = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_FIRING   = 2'd1,
        PH_COOLDOWN = 2'd2
    } phase_t;

    typedef struct packed {
        logic [MS_W-1:0] pulse_length_ms;
        logic [MS_W-1:0] max_on_ms;
        logic [MS_W-1:0] cooldown_ms;
        logic            button_present;
        logic            button_active_level;
        logic            fire_polarity;
    } cfg_t;

    typedef struct packed {
        logic               gate_level;
        phase_t             phase;
        logic               fire_accepted;
        logic [READY_W-1:0] ready_in_ms;
    } result_t;

endpackage

@@ rtl/coil_pulse_holdoff_timer_unit.sv @@
// ----------------------------------------------------------------------------
// coil_pulse_holdoff_timer_unit
// one-shot coil pulse driver with on-time cap and cooldown holdoff
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | command, advance_ms, button_level
//   out     | out_valid / out_ready| gate_level, phase, fire_accepted,
//           |                      | ready_in_ms
//   cfg     | cfg_write            | cfg_index, cfg_data
//
// one request per cycle sustained while the output is not stalled
// a request sits in the input register and is processed against the timer
// state combinationally, loading the result register
// reset clears the timer state, the handshake flags and loads default config
// a stalled result holds the input register; in_ready drops only when both are full
// ----------------------------------------------------------------------------
module coil_pulse_holdoff_timer_unit
    import chpt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             command,
    input  logic [MS_W-1:0]        advance_ms,
    input  logic                   button_level,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   gate_level,
    output logic [1:0]             phase,
    output logic                   fire_accepted,
    output logic [READY_W-1:0]     ready_in_ms,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t            cfg;
    result_t         step_result;
    logic            req_valid_reg, req_valid_next;
    command_t        req_cmd_reg;
    logic [MS_W-1:0] req_adv_reg;
    logic            req_btn_reg;
    logic            res_valid_reg, res_valid_next;
    result_t         res_reg;
    logic            step_en;

    assign step_en  = req_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || step_en;

    assign req_valid_next = (in_valid && in_ready) || (req_valid_reg && !step_en);
    assign res_valid_next = step_en || (res_valid_reg && !out_ready);

    chpt_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    chpt_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .command      (req_cmd_reg),
        .advance_ms   (req_adv_reg),
        .button_level (req_btn_reg),
        .cfg          (cfg),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_cmd_reg <= command_t'(command);
            req_adv_reg <= advance_ms;
            req_btn_reg <= button_level;
        end
        if (step_en)
            res_reg <= step_result;
    end

    assign out_valid     = res_valid_reg;
    assign gate_level    = res_reg.gate_level;
    assign phase         = res_reg.phase;
    assign fire_accepted = res_reg.fire_accepted;
    assign ready_in_ms   = res_reg.ready_in_ms;

    a_fire_means_firing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fire_accepted |-> phase == PH_FIRING)
        else $error("accepted fire without firing phase");

    a_idle_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == PH_IDLE |-> ready_in_ms == '0)
        else $error("idle result with nonzero ready time");

    a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !step_en |=> req_valid_reg && $stable(req_cmd_reg))
        else $error("pending request lost while stalled");

    a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> res_valid_reg)
        else $error("processed request produced no result");

endmodule

@@ rtl/chpt_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// chpt_cfg_regs
// configuration register file, written by index, no read-back
// ----------------------------------------------------------------------------
module chpt_cfg_regs
    import chpt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_length_ms     <= PULSE_LENGTH_RST;
            cfg_reg.max_on_ms           <= MAX_ON_RST;
            cfg_reg.cooldown_ms         <= COOLDOWN_RST;
            cfg_reg.button_present      <= 1'b1;
            cfg_reg.button_active_level <= 1'b1;
            cfg_reg.fire_polarity       <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PULSE_LENGTH:  cfg_reg.pulse_length_ms     <= cfg_data;
                REG_MAX_ON:        cfg_reg.max_on_ms           <= cfg_data;
                REG_COOLDOWN:      cfg_reg.cooldown_ms         <= cfg_data;
                REG_BUTTON_PRES:   cfg_reg.button_present      <= cfg_data[0];
                REG_BUTTON_ACTIVE: cfg_reg.button_active_level <= cfg_data[0];
                REG_FIRE_POL:      cfg_reg.fire_polarity       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/chpt_step.sv @@
// ----------------------------------------------------------------------------
// chpt_step
// timer state and the combinational update for one request
// ----------------------------------------------------------------------------
module chpt_step
    import chpt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  command_t        command,
    input  logic [MS_W-1:0] advance_ms,
    input  logic            button_level,
    input  cfg_t            cfg,
    output result_t         result
);

    // elapsed times since pulse start and cooldown start, modulo 2^32
    logic [TIME_W-1:0] pulse_elapsed_reg, pulse_elapsed_next;
    logic [TIME_W-1:0] cool_elapsed_reg, cool_elapsed_next;
    phase_t            phase_reg, phase_next;
    logic              btn_now_reg, btn_now_next;
    logic              btn_before_reg, btn_before_next;
    logic              accepted;
    logic [TIME_W-1:0] pe_adv;
    logic [TIME_W-1:0] ce_adv;
    phase_t            phase_timed;
    logic [READY_W-1:0] pulse_rem;

    assign pe_adv = pulse_elapsed_reg + {{(TIME_W-MS_W){1'b0}}, advance_ms};
    assign ce_adv = cool_elapsed_reg + {{(TIME_W-MS_W){1'b0}}, advance_ms};

    always_comb
    begin
        pulse_elapsed_next = pulse_elapsed_reg;
        cool_elapsed_next  = cool_elapsed_reg;
        phase_next         = phase_reg;
        btn_now_next       = btn_now_reg;
        btn_before_next    = btn_before_reg;
        phase_timed        = phase_reg;
        accepted           = 1'b0;
        case (command)
            CMD_UPDATE:
            begin
                pulse_elapsed_next = pe_adv;
                cool_elapsed_next  = ce_adv;
                case (phase_reg)
                    PH_FIRING:
                    begin
                        if (pe_adv >= {{(TIME_W-MS_W){1'b0}}, cfg.max_on_ms})
                        begin
                            // cap end, zero cooldown falls straight through to idle
                            cool_elapsed_next = '0;
                            phase_timed = (cfg.cooldown_ms == '0) ? PH_IDLE : PH_COOLDOWN;
                        end
                        else if (pe_adv >= {{(TIME_W-MS_W){1'b0}}, cfg.pulse_length_ms})
                        begin
                            cool_elapsed_next = '0;
                            phase_timed = PH_COOLDOWN;
                        end
                    end
                    PH_COOLDOWN:
                    begin
                        if (ce_adv >= {{(TIME_W-MS_W){1'b0}}, cfg.cooldown_ms})
                            phase_timed = PH_IDLE;
                    end
                    default: ;
                endcase
                if (cfg.button_present)
                begin
                    btn_before_next = btn_now_reg;
                    btn_now_next    = (button_level == cfg.button_active_level);
                end
                else
                begin
                    btn_before_next = 1'b0;
                    btn_now_next    = 1'b0;
                end
                phase_next = phase_timed;
                if (btn_now_next && !btn_before_next && phase_timed == PH_IDLE)
                begin
                    accepted           = 1'b1;
                    phase_next         = PH_FIRING;
                    pulse_elapsed_next = '0;
                end
            end
            CMD_FIRE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    accepted           = 1'b1;
                    phase_next         = PH_FIRING;
                    pulse_elapsed_next = '0;
                end
            end
            CMD_RESET:
            begin
                phase_next = PH_IDLE;
            end
            default: ;
        endcase
    end

    // status after the request
    always_comb
    begin
        pulse_rem = '0;
        if (pulse_elapsed_next < {{(TIME_W-MS_W){1'b0}}, cfg.pulse_length_ms})
            pulse_rem = {1'b0, cfg.pulse_length_ms - pulse_elapsed_next[MS_W-1:0]};
        result.phase         = phase_next;
        result.fire_accepted = accepted;
        result.gate_level    = (phase_next == PH_FIRING) ? cfg.fire_polarity
                                                         : ~cfg.fire_polarity;
        case (phase_next)
            PH_FIRING:
                result.ready_in_ms = pulse_rem + {1'b0, cfg.cooldown_ms};
            PH_COOLDOWN:
            begin
                if (cool_elapsed_next < {{(TIME_W-MS_W){1'b0}}, cfg.cooldown_ms})
                    result.ready_in_ms = {1'b0, cfg.cooldown_ms - cool_elapsed_next[MS_W-1:0]};
                else
                    result.ready_in_ms = '0;
            end
            default:
                result.ready_in_ms = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_elapsed_reg <= '0;
            cool_elapsed_reg  <= '0;
            phase_reg         <= PH_IDLE;
            btn_now_reg       <= 1'b0;
            btn_before_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            pulse_elapsed_reg <= pulse_elapsed_next;
            cool_elapsed_reg  <= cool_elapsed_next;
            phase_reg         <= phase_next;
            btn_now_reg       <= btn_now_next;
            btn_before_reg    <= btn_before_next;
        end
    end

endmodule

@@ sim/tb_coil_pulse_holdoff_timer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coil_pulse_holdoff_timer_unit
// Self-checking bench for the coil pulse holdoff timer. A behavioral copy of
// the timer predicts the status for every accepted request, and the status
// results are checked in order. The bench runs directed cases for the cap,
// the pulse end, the cooldown, the button and the polarity settings. It also
// runs a pass across the 32-bit clock wrap, a long output stall and random
// requests under several register settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_coil_pulse_holdoff_timer_unit
    import chpt_pkg::*;
;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             command = CMD_UPDATE;
    logic [MS_W-1:0]        advance_ms = '0;
    logic                   button_level = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   gate_level;
    logic [1:0]             phase;
    logic                   fire_accepted;
    logic [READY_W-1:0]     ready_in_ms;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_PULSE_LENGTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // timer state as predicted
    logic [TIME_W-1:0] clock_now = '0;
    logic [TIME_W-1:0] pulse_began = '0;
    logic [TIME_W-1:0] cool_began = '0;
    phase_t            coil_phase = PH_IDLE;
    logic              btn_pressed = 1'b0;
    logic              btn_was_pressed = 1'b0;

    logic [MS_W-1:0] set_pulse_len = PULSE_LENGTH_RST;
    logic [MS_W-1:0] set_max_on = MAX_ON_RST;
    logic [MS_W-1:0] set_cooldown = COOLDOWN_RST;
    logic            set_btn_present = 1'b1;
    logic            set_btn_active = 1'b1;
    logic            set_fire_pol = 1'b1;

    result_t pending_status[$];
    result_t status_want;
    int      error_count = 0;
    int      cycle_count = 0;
    int      hold_off_cycles = 0;
    int      recv_stall;
    bit      sender_idles = 1'b1;
    bit      receiver_idles = 1'b1;

    coil_pulse_holdoff_timer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .advance_ms    (advance_ms),
        .button_level  (button_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gate_level    (gate_level),
        .phase         (phase),
        .fire_accepted (fire_accepted),
        .ready_in_ms   (ready_in_ms),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t next_coil_status(input logic [1:0] cmd,
                                                 input logic [MS_W-1:0] adv,
                                                 input logic btn);
        result_t           status;
        logic              fired;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] left;
        fired = 1'b0;
        case (cmd)
            CMD_UPDATE:
            begin
                clock_now = clock_now + adv;
                elapsed = clock_now - pulse_began;
                if (coil_phase == PH_FIRING && elapsed >= set_max_on)
                begin
                    cool_began = clock_now;
                    coil_phase = PH_COOLDOWN;
                end
                if (coil_phase == PH_FIRING)
                begin
                    if (elapsed >= set_pulse_len)
                    begin
                        cool_began = clock_now;
                        coil_phase = PH_COOLDOWN;
                    end
                end
                else if (coil_phase == PH_COOLDOWN)
                begin
                    if (clock_now - cool_began >= set_cooldown)
                        coil_phase = PH_IDLE;
                end
                if (!set_btn_present)
                begin
                    btn_was_pressed = 1'b0;
                    btn_pressed = 1'b0;
                end
                else
                begin
                    btn_was_pressed = btn_pressed;
                    btn_pressed = (btn == set_btn_active);
                end
                if (btn_pressed && !btn_was_pressed && coil_phase == PH_IDLE)
                begin
                    pulse_began = clock_now;
                    coil_phase = PH_FIRING;
                    fired = 1'b1;
                end
            end
            CMD_FIRE:
            begin
                if (coil_phase == PH_IDLE)
                begin
                    pulse_began = clock_now;
                    coil_phase = PH_FIRING;
                    fired = 1'b1;
                end
            end
            CMD_RESET:
                coil_phase = PH_IDLE;
            default:
                ;
        endcase

        status.gate_level = (coil_phase == PH_FIRING) ? set_fire_pol : ~set_fire_pol;
        status.phase = coil_phase;
        status.fire_accepted = fired;
        if (coil_phase == PH_FIRING)
        begin
            elapsed = clock_now - pulse_began;
            left = (elapsed >= set_pulse_len) ? '0 : set_pulse_len - elapsed;
            status.ready_in_ms = READY_W'(left + set_cooldown);
        end
        else if (coil_phase == PH_COOLDOWN)
        begin
            elapsed = clock_now - cool_began;
            status.ready_in_ms = (elapsed >= set_cooldown) ? '0
                                 : READY_W'(set_cooldown - elapsed);
        end
        else
            status.ready_in_ms = '0;
        return status;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [MS_W-1:0] adv,
                                input logic btn);
        int gap;
        gap = sender_idles ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        advance_ms   <= adv;
        button_level <= btn;
        do @(posedge clk); while (!in_ready);
        pending_status.push_back(next_coil_status(cmd, adv, btn));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_settings(input logic [MS_W-1:0] pulse_len,
                                    input logic [MS_W-1:0] max_on,
                                    input logic [MS_W-1:0] cooldown,
                                    input logic btn_present, input logic btn_active,
                                    input logic fire_pol);
        drain_results();
        put_reg(REG_PULSE_LENGTH, pulse_len);
        put_reg(REG_MAX_ON, max_on);
        put_reg(REG_COOLDOWN, cooldown);
        put_reg(REG_BUTTON_PRES, {15'd0, btn_present});
        put_reg(REG_BUTTON_ACTIVE, {15'd0, btn_active});
        put_reg(REG_FIRE_POL, {15'd0, fire_pol});
        cfg_write <= 1'b0;
        set_pulse_len = pulse_len;
        set_max_on = max_on;
        set_cooldown = cooldown;
        set_btn_present = btn_present;
        set_btn_active = btn_active;
        set_fire_pol = fire_pol;
    endtask

    task automatic send_random_requests(input int count);
        int              pick;
        logic [1:0]      cmd;
        logic [MS_W-1:0] adv;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                cmd = CMD_UPDATE;
            else if (pick < 85)
                cmd = CMD_FIRE;
            else if (pick < 93)
                cmd = CMD_RESET;
            else
                cmd = CMD_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                adv = '0;
            else if (pick < 45)
                adv = 16'($urandom_range(0, 63));
            else if (pick < 75)
                adv = 16'($urandom_range(0, 1023));
            else
                adv = 16'($urandom_range(0, 65535));
            send_request(cmd, adv, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_default_sequence();
        send_request(CMD_UPDATE, 16'd0, 1'b1);
        send_request(CMD_UPDATE, 16'd10, 1'b1);
        send_request(CMD_FIRE, 16'd0, 1'b0);
        send_request(CMD_UPDATE, 16'd40, 1'b0);
        send_request(CMD_UPDATE, 16'd499, 1'b0);
        send_request(CMD_UPDATE, 16'd1, 1'b0);
        send_request(CMD_FIRE, 16'hFFFF, 1'b1);
        send_request(CMD_RESET, 16'hFFFF, 1'b1);
        send_request(CMD_UNUSED, 16'd0, 1'b0);
        send_request(CMD_UPDATE, 16'hFFFF, 1'b1);
        send_request(CMD_UPDATE, 16'hFFFF, 1'b1);
    endtask

    task automatic test_special_cases();
        // cap ends the pulse and a zero cooldown ends at once
        program_settings(16'd200, 16'd20, 16'd0, 1'b1, 1'b1, 1'b1);
        send_request(CMD_RESET, 16'd0, 1'b0);
        send_request(CMD_FIRE, 16'd0, 1'b0);
        send_request(CMD_UPDATE, 16'd20, 1'b0);
        // normal end stays in cooldown for one update
        program_settings(16'd10, 16'd100, 16'd0, 1'b1, 1'b1, 1'b1);
        send_request(CMD_FIRE, 16'd0, 1'b0);
        send_request(CMD_UPDATE, 16'd10, 1'b0);
        send_request(CMD_UPDATE, 16'd0, 1'b0);
        // pulse length lowered below elapsed time while firing
        program_settings(16'd50, 16'd100, 16'd300, 1'b1, 1'b1, 1'b1);
        send_request(CMD_FIRE, 16'd0, 1'b0);
        send_request(CMD_UPDATE, 16'd30, 1'b0);
        program_settings(16'd10, 16'd100, 16'd300, 1'b1, 1'b1, 1'b1);
        send_request(CMD_UNUSED, 16'd0, 1'b0);
        send_request(CMD_FIRE, 16'd0, 1'b0);
        send_request(CMD_UPDATE, 16'd0, 1'b0);
        // button absent, active low button, inverted gate
        program_settings(16'd5, 16'd100, 16'd7, 1'b0, 1'b0, 1'b0);
        send_request(CMD_UPDATE, 16'd7, 1'b0);
        send_request(CMD_FIRE, 16'd0, 1'b0);
        program_settings(16'd5, 16'd100, 16'd7, 1'b1, 1'b0, 1'b0);
        send_request(CMD_UPDATE, 16'd100, 1'b1);
        send_request(CMD_UPDATE, 16'd7, 1'b0);
        send_request(CMD_RESET, 16'd0, 1'b0);
    endtask

    task automatic test_clock_wrap();
        logic [TIME_W-1:0] gap_to_top;
        program_settings(PULSE_LENGTH_RST, MAX_ON_RST, COOLDOWN_RST, 1'b1, 1'b1, 1'b1);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        // only time differences matter, so shift the predicted time base near the wrap
        gap_to_top = 32'hFFFF_FFF0 - clock_now;
        clock_now = clock_now + gap_to_top;
        pulse_began = pulse_began + gap_to_top;
        cool_began = cool_began + gap_to_top;
        send_request(CMD_RESET, 16'd0, 1'b0);
        send_request(CMD_FIRE, 16'd0, 1'b0);
        send_request(CMD_UPDATE, 16'd20, 1'b0);
        send_request(CMD_UPDATE, 16'd40, 1'b0);
        drain_results();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_output_stall();
        program_settings(16'd40, 16'd60, 16'd100, 1'b1, 1'b1, 1'b1);
        sender_idles = 1'b0;
        hold_off_cycles = 300;
        send_random_requests(40);
        sender_idles = 1'b1;
        drain_results();
    endtask

    task automatic test_random_settings();
        program_settings(PULSE_LENGTH_RST, MAX_ON_RST, COOLDOWN_RST, 1'b1, 1'b1, 1'b1);
        send_random_requests(240);
        program_settings(16'd1, 16'd1, 16'd0, 1'b1, 1'b1, 1'b0);
        send_random_requests(240);
        program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
        send_random_requests(240);
        program_settings(16'd200, 16'd30, 16'd0, 1'b1, 1'b1, 1'b1);
        send_random_requests(240);
        program_settings(16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)),
                         16'($urandom_range(0, 800)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_random_requests(240);
        program_settings(16'd20, 16'hFFFF, 16'd1000, 1'b0, 1'b1, 1'b0);
        send_random_requests(240);
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                recv_stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else if (receiver_idles)
                recv_stall = $urandom_range(0, 15);
            else
                recv_stall = 0;
            if (recv_stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (recv_stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
            begin
                $error("status result with no request outstanding");
                error_count++;
            end
            else
            begin
                status_want = pending_status.pop_front();
                check_field("gate_level", 32'(status_want.gate_level), 32'(gate_level));
                check_field("phase", 32'(status_want.phase), 32'(phase));
                check_field("fire_accepted", 32'(status_want.fire_accepted),
                            32'(fire_accepted));
                check_field("ready_in_ms", 32'(status_want.ready_in_ms), 32'(ready_in_ms));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_coil_pulse_holdoff_timer_unit failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_sequence();
        test_special_cases();
        test_clock_wrap();
        test_output_stall();
        test_random_settings();
        drain_results();
        if (error_count == 0)
            $display("tb_coil_pulse_holdoff_timer_unit passed");
        else
            $display("tb_coil_pulse_holdoff_timer_unit failed");
        $finish;
    end

endmodule
